### hw/rtl/sfcf_pkg.sv
// Shared types and constants of the SPI flash command framer.
// Holds the job descriptor passed between front and back, the config
// register map, result layout and the back-end phase encoding.
package sfcf_pkg;

    localparam int ADDR_W    = 25;
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 3;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PROG   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SECTOR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DATA   = 3'd4;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_OP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WREN_OP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OP  = 3'd5;

    // Config reset values
    localparam logic [BYTE_W-1:0] RST_READ_OP   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_PROG_OP   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_WREN_OP   = 8'd6;
    localparam logic [BYTE_W-1:0] RST_SECTOR_OP = 8'd32;
    localparam logic [BYTE_W-1:0] RST_BLOCK_OP  = 8'd216;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ARG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_OP   = 2'd2;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_READ,
        OP_PROG
    } op_t;

    typedef enum logic [2:0] {
        JOB_ERR_ARG,
        JOB_ERR_DATA,
        JOB_READ,
        JOB_SECTOR,
        JOB_BLOCK,
        JOB_SLOT,
        JOB_PROG_HDR,
        JOB_PROG_DATA
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic               frame_end;
    } job_t;

    typedef struct packed {
        logic               four_byte;
        logic [BYTE_W-1:0]  read_op;
        logic [BYTE_W-1:0]  prog_op;
        logic [BYTE_W-1:0]  wren_op;
        logic [BYTE_W-1:0]  sector_op;
        logic [BYTE_W-1:0]  block_op;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  spi_byte;
        logic               frame_end;
        logic               wait_ready;
        logic               capture;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        PH_WREN,
        PH_OPCODE,
        PH_ADDR3,
        PH_ADDR2,
        PH_ADDR1,
        PH_ADDR0,
        PH_DATA,
        PH_ERROR
    } phase_t;

endpackage

### hw/rtl/sfcf_front.sv
// Front end of the SPI flash command framer: accepts requests, tracks the
// active operation, page chunks and addresses, and emits at most one job per item.
// Depends on sfcf_pkg.
module sfcf_front #(
    parameter int PAGE_BYTES = 256,
    parameter int CHIP_BYTES = 16777216
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sfcf_pkg::MODE_W-1:0] mode,
    input  logic [sfcf_pkg::ADDR_W-1:0] address,
    input  logic [sfcf_pkg::LEN_W-1:0]  length,
    input  logic [sfcf_pkg::BYTE_W-1:0] data_byte,
    output logic                        job_valid,
    input  logic                        job_ready,
    output sfcf_pkg::job_t              job
);

    // Page size is a power of two; offset in page is a plain bit slice
    localparam int PAGE_AW  = $clog2(PAGE_BYTES);
    localparam int CHUNK_W  = $clog2(PAGE_BYTES + 1);
    localparam int AWIDE    = sfcf_pkg::ADDR_W + 1;
    localparam logic [AWIDE-1:0] CHIP_LIM = AWIDE'(CHIP_BYTES);

    sfcf_pkg::op_t                  active_reg, active_next;
    logic [sfcf_pkg::ADDR_W-1:0]    cur_addr_reg, cur_addr_next;
    logic [sfcf_pkg::LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [CHUNK_W-1:0]             chunk_left_reg, chunk_left_next;

    logic                           accept;
    logic                           addr_over;
    logic                           bad;
    logic [PAGE_AW-1:0]             page_off;
    logic [CHUNK_W-1:0]             room;
    logic [CHUNK_W-1:0]             chunk_first;
    logic [CHUNK_W-1:0]             chunk_cur;
    logic [CHUNK_W-1:0]             chunk_dec;
    logic [sfcf_pkg::LEN_W-1:0]     bytes_dec;
    logic [AWIDE-1:0]               addr_inc;
    logic                           chunk_end;

    assign in_ready = job_ready;
    assign accept   = in_valid && job_ready;

    // Argument checks
    assign addr_over = {1'b0, address} >= CHIP_LIM;
    assign bad       = (active_reg != sfcf_pkg::OP_IDLE) || addr_over;

    // Page chunk bookkeeping: room left in page, clipped to remaining bytes
    assign page_off    = cur_addr_reg[PAGE_AW-1:0];
    assign room        = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(page_off);
    assign chunk_first = (sfcf_pkg::LEN_W'(room) < bytes_left_reg) ? room
                                                                   : bytes_left_reg[CHUNK_W-1:0];
    assign chunk_cur   = (chunk_left_reg == '0) ? chunk_first : chunk_left_reg;
    assign chunk_dec   = chunk_cur - CHUNK_W'(1);
    assign chunk_end   = (chunk_dec == '0);
    assign bytes_dec   = bytes_left_reg - sfcf_pkg::LEN_W'(1);
    assign addr_inc    = {1'b0, cur_addr_reg} + AWIDE'(1);

    // Classify the item and update operation state
    always_comb
    begin
        active_next     = active_reg;
        cur_addr_next   = cur_addr_reg;
        bytes_left_next = bytes_left_reg;
        chunk_left_next = chunk_left_reg;
        job_valid       = 1'b0;
        job.kind        = sfcf_pkg::JOB_ERR_ARG;
        job.addr        = address;
        job.data        = data_byte;
        job.frame_end   = 1'b0;

        if (accept)
        begin
            case (mode) inside
                sfcf_pkg::MODE_READ, sfcf_pkg::MODE_PROG:
                begin
                    if (bad || (length == '0))
                    begin
                        job_valid = 1'b1;
                    end
                    else if (mode == sfcf_pkg::MODE_READ)
                    begin
                        active_next     = sfcf_pkg::OP_READ;
                        bytes_left_next = length;
                        cur_addr_next   = address;
                        job_valid       = 1'b1;
                        job.kind        = sfcf_pkg::JOB_READ;
                    end
                    else
                    begin
                        // Program start is silent; headers go with data
                        active_next     = sfcf_pkg::OP_PROG;
                        bytes_left_next = length;
                        chunk_left_next = '0;
                        cur_addr_next   = address;
                    end
                end
                sfcf_pkg::MODE_SECTOR, sfcf_pkg::MODE_BLOCK:
                begin
                    job_valid = 1'b1;
                    if (!bad)
                    begin
                        job.kind = (mode == sfcf_pkg::MODE_SECTOR) ? sfcf_pkg::JOB_SECTOR
                                                                  : sfcf_pkg::JOB_BLOCK;
                    end
                end
                sfcf_pkg::MODE_DATA:
                begin
                    job_valid = 1'b1;
                    case (active_reg)
                        sfcf_pkg::OP_READ:
                        begin
                            bytes_left_next = bytes_dec;
                            job.kind        = sfcf_pkg::JOB_SLOT;
                            job.frame_end   = (bytes_dec == '0);
                            if (bytes_dec == '0)
                            begin
                                active_next = sfcf_pkg::OP_IDLE;
                            end
                        end
                        sfcf_pkg::OP_PROG:
                        begin
                            job.kind        = (chunk_left_reg == '0) ? sfcf_pkg::JOB_PROG_HDR
                                                                     : sfcf_pkg::JOB_PROG_DATA;
                            job.addr        = cur_addr_reg;
                            job.frame_end   = chunk_end;
                            chunk_left_next = chunk_dec;
                            bytes_left_next = bytes_dec;
                            if (chunk_end)
                            begin
                                // Wrap to zero at chip end, only at chunk end
                                cur_addr_next = (addr_inc >= CHIP_LIM) ? '0
                                                : addr_inc[sfcf_pkg::ADDR_W-1:0];
                                if (bytes_dec == '0)
                                begin
                                    active_next = sfcf_pkg::OP_IDLE;
                                end
                            end
                            else
                            begin
                                cur_addr_next = addr_inc[sfcf_pkg::ADDR_W-1:0];
                            end
                        end
                        default:
                        begin
                            job.kind = sfcf_pkg::JOB_ERR_DATA;
                        end
                    endcase
                end
                default:
                begin
                    job_valid = 1'b0;
                end
            endcase
        end
    end

    // Operation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= sfcf_pkg::OP_IDLE;
            cur_addr_reg   <= '0;
            bytes_left_reg <= '0;
            chunk_left_reg <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            cur_addr_reg   <= cur_addr_next;
            bytes_left_reg <= bytes_left_next;
            chunk_left_reg <= chunk_left_next;
        end
    end

    // A read in progress always has slots left
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg == sfcf_pkg::OP_READ) |-> (bytes_left_reg != '0))
        else $error("read active with no slots left");

    // An open program chunk never outruns the remaining byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        ((active_reg == sfcf_pkg::OP_PROG) && (chunk_left_reg != '0))
        |-> (sfcf_pkg::LEN_W'(chunk_left_reg) <= bytes_left_reg))
        else $error("program chunk larger than remaining bytes");

endmodule

### hw/rtl/sfcf_queue.sv
// Small register FIFO between the framer front and back ends.
// Generic width and depth; no package dependency.
module sfcf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/sfcf_back.sv
// Back end of the SPI flash command framer: expands each job into its SPI
// bytes, one per cycle unless stalled, into an output register. Depends on sfcf_pkg.
module sfcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sfcf_pkg::cfg_t    cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  sfcf_pkg::job_t    job,
    output logic              out_valid,
    input  logic              out_ready,
    output sfcf_pkg::result_t out_res
);

    sfcf_pkg::phase_t   phase_reg, phase_next;
    sfcf_pkg::phase_t   phase_step;
    sfcf_pkg::phase_t   phase_start;
    logic               cur_valid_reg, cur_valid_next;
    sfcf_pkg::job_t     job_reg, job_next;
    logic               out_valid_reg, out_valid_next;
    sfcf_pkg::result_t  out_res_reg, out_res_next;
    sfcf_pkg::result_t  res;
    logic               done;
    logic               step;
    logic               load;

    // First byte of a new job
    always_comb
    begin
        case (job.kind) inside
            sfcf_pkg::JOB_ERR_ARG, sfcf_pkg::JOB_ERR_DATA:
                phase_start = sfcf_pkg::PH_ERROR;
            sfcf_pkg::JOB_READ:
                phase_start = sfcf_pkg::PH_OPCODE;
            sfcf_pkg::JOB_SECTOR, sfcf_pkg::JOB_BLOCK, sfcf_pkg::JOB_PROG_HDR:
                phase_start = sfcf_pkg::PH_WREN;
            default:
                phase_start = sfcf_pkg::PH_DATA;
        endcase
    end

    // Byte generator: current byte and following phase
    always_comb
    begin
        res        = '0;
        done       = 1'b0;
        phase_step = phase_reg;
        unique case (phase_reg)
            sfcf_pkg::PH_WREN:
            begin
                res.spi_byte   = cfg.wren_op;
                res.frame_end  = 1'b1;
                res.wait_ready = 1'b1;
                phase_step     = sfcf_pkg::PH_OPCODE;
            end
            sfcf_pkg::PH_OPCODE:
            begin
                case (job_reg.kind)
                    sfcf_pkg::JOB_READ:
                    begin
                        res.spi_byte   = cfg.read_op;
                        res.wait_ready = 1'b1;
                    end
                    sfcf_pkg::JOB_SECTOR: res.spi_byte = cfg.sector_op;
                    sfcf_pkg::JOB_BLOCK:  res.spi_byte = cfg.block_op;
                    default:              res.spi_byte = cfg.prog_op;
                endcase
                phase_step = cfg.four_byte ? sfcf_pkg::PH_ADDR3 : sfcf_pkg::PH_ADDR2;
            end
            sfcf_pkg::PH_ADDR3:
            begin
                res.spi_byte = {7'b0, job_reg.addr[24]};
                phase_step   = sfcf_pkg::PH_ADDR2;
            end
            sfcf_pkg::PH_ADDR2:
            begin
                res.spi_byte = job_reg.addr[23:16];
                phase_step   = sfcf_pkg::PH_ADDR1;
            end
            sfcf_pkg::PH_ADDR1:
            begin
                res.spi_byte = job_reg.addr[15:8];
                phase_step   = sfcf_pkg::PH_ADDR0;
            end
            sfcf_pkg::PH_ADDR0:
            begin
                res.spi_byte  = job_reg.addr[7:0];
                res.frame_end = (job_reg.kind == sfcf_pkg::JOB_SECTOR) ||
                                (job_reg.kind == sfcf_pkg::JOB_BLOCK);
                done          = (job_reg.kind != sfcf_pkg::JOB_PROG_HDR);
                phase_step    = sfcf_pkg::PH_DATA;
            end
            sfcf_pkg::PH_DATA:
            begin
                res.spi_byte  = (job_reg.kind == sfcf_pkg::JOB_SLOT) ? '0 : job_reg.data;
                res.frame_end = job_reg.frame_end;
                res.capture   = (job_reg.kind == sfcf_pkg::JOB_SLOT);
                done          = 1'b1;
            end
            sfcf_pkg::PH_ERROR:
            begin
                res.error_code = (job_reg.kind == sfcf_pkg::JOB_ERR_ARG) ? sfcf_pkg::ERR_BAD_ARG
                                                                         : sfcf_pkg::ERR_NO_OP;
                done           = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        res.last = done;
    end

    // Job sequencing and output register
    assign step      = cur_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !cur_valid_reg || (step && done);
    assign load      = job_ready && job_valid;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        phase_next     = phase_reg;
        job_next       = job_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            phase_next     = phase_start;
            job_next       = job;
        end
        else if (step && done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (step)
        begin
            phase_next = phase_step;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= sfcf_pkg::PH_WREN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Error results are single, empty bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.error_code != sfcf_pkg::ERR_NONE))
        |-> (out_res_reg.last && (out_res_reg.spi_byte == '0) && !out_res_reg.frame_end))
        else $error("error result carries payload");

    // Read data capture never marks a frame start or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.capture)
        |-> (!out_res_reg.wait_ready && (out_res_reg.error_code == sfcf_pkg::ERR_NONE)))
        else $error("capture byte marked as frame start or error");

    // High address byte only in four-byte addressing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && (phase_reg == sfcf_pkg::PH_ADDR3)) |-> cfg.four_byte)
        else $error("fourth address byte in three-byte mode");

endmodule

### hw/rtl/spi_flash_command_framer.sv
// Top level of the SPI flash command framer: config registers, front end,
// job queue and back end. Depends on sfcf_pkg, sfcf_front, sfcf_queue, sfcf_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per transfer. Modes 0..3
//   start a read, program, sector erase or block erase; mode 4 carries one
//   program data byte or one read slot. Modes 5..7 are taken and dropped.
//   Output channel (out_valid/out_ready): one SPI byte per transfer with its
//   frame_end, wait_ready, capture and error_code marks; last flags the
//   final byte caused by a request.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   only while no request is in flight.
//   A request's job passes the job queue, the back end's job register and the output register.
//   Throughput: the back end emits one byte per cycle unless out_ready stalls
//   it. A program start and modes 5..7 give no bytes, an error gives 1, a
//   read start 4 or 5, an erase 5 or 6, a read slot or data byte 1, and a data
//   byte that opens a page chunk 6 or 7 (write enable, opcode, address, data).
//   A QUEUE_DEPTH-entry job queue sits between the front and back ends; the
//   input stalls only when it is full.
//   Reset clears the operation state, the queue and the output valid flag and
//   loads the default opcodes with three-byte addressing.
//   When the receiver stalls, the output byte holds and the queue absorbs
//   up to QUEUE_DEPTH further jobs.
module spi_flash_command_framer #(
    parameter int PAGE_BYTES  = 256,
    parameter int CHIP_BYTES  = 16777216,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfcf_pkg::MODE_W-1:0]    mode,
    input  logic [sfcf_pkg::ADDR_W-1:0]    address,
    input  logic [sfcf_pkg::LEN_W-1:0]     length,
    input  logic [sfcf_pkg::BYTE_W-1:0]    data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sfcf_pkg::BYTE_W-1:0]    spi_byte,
    output logic                           frame_end,
    output logic                           wait_ready,
    output logic                           capture,
    output logic [sfcf_pkg::ERR_W-1:0]     error_code,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfcf_pkg::BYTE_W-1:0]    cfg_data
);

    sfcf_pkg::cfg_t     cfg_reg, cfg_next;
    logic               fr_job_valid;
    logic               fr_job_ready;
    sfcf_pkg::job_t     fr_job;
    logic               bk_job_valid;
    logic               bk_job_ready;
    sfcf_pkg::job_t     bk_job;
    sfcf_pkg::result_t  out_res;

    // Config register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sfcf_pkg::CFG_FOUR_BYTE: cfg_next.four_byte = cfg_data[0];
                sfcf_pkg::CFG_READ_OP:   cfg_next.read_op   = cfg_data;
                sfcf_pkg::CFG_PROG_OP:   cfg_next.prog_op   = cfg_data;
                sfcf_pkg::CFG_WREN_OP:   cfg_next.wren_op   = cfg_data;
                sfcf_pkg::CFG_SECTOR_OP: cfg_next.sector_op = cfg_data;
                sfcf_pkg::CFG_BLOCK_OP:  cfg_next.block_op  = cfg_data;
                default:                 cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_byte <= 1'b0;
            cfg_reg.read_op   <= sfcf_pkg::RST_READ_OP;
            cfg_reg.prog_op   <= sfcf_pkg::RST_PROG_OP;
            cfg_reg.wren_op   <= sfcf_pkg::RST_WREN_OP;
            cfg_reg.sector_op <= sfcf_pkg::RST_SECTOR_OP;
            cfg_reg.block_op  <= sfcf_pkg::RST_BLOCK_OP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Request classification
    sfcf_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .CHIP_BYTES (CHIP_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .address    (address),
        .length     (length),
        .data_byte  (data_byte),
        .job_valid  (fr_job_valid),
        .job_ready  (fr_job_ready),
        .job        (fr_job)
    );

    // Job queue
    sfcf_queue #(
        .WIDTH (($bits(sfcf_pkg::job_t))),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_job_valid),
        .push_ready (fr_job_ready),
        .push_data  (fr_job),
        .pop_valid  (bk_job_valid),
        .pop_ready  (bk_job_ready),
        .pop_data   (bk_job)
    );

    // Byte expansion
    sfcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (bk_job_valid),
        .job_ready  (bk_job_ready),
        .job        (bk_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign spi_byte   = out_res.spi_byte;
    assign frame_end  = out_res.frame_end;
    assign wait_ready = out_res.wait_ready;
    assign capture    = out_res.capture;
    assign error_code = out_res.error_code;
    assign last       = out_res.last;

endmodule
